FILE: rtl/tt_pkg.sv
// Package for the triangle tangent unit: field widths, datapath widths and
// fixed-point constants. Depends on nothing.
`default_nettype none
package tt_pkg;

    localparam int POS_W  = 32;   // input field width, Q16.16
    localparam int OUT_W  = 18;   // result field width, Q1.16
    localparam int DIF_W  = 33;   // edge and uv delta width
    localparam int PROD_W = 66;   // product of two deltas
    localparam int ACC_W  = 68;   // multiply-accumulate register
    localparam int MAG_W  = 67;   // magnitude of a tangent component
    localparam int DS_W   = 80;   // biased determinant, units of 2^-40
    localparam int EPS_W  = 63;   // epsilon term, saturates at 2^62
    localparam int RAD_W  = 64;   // radicand, remainder and divisor
    localparam int DEN_W  = 82;   // divisor aligned to the top quotient bit
    localparam int Q_W    = 18;   // quotient bits

    localparam logic [DS_W-1:0]  BIAS_Q40 = DS_W'(10995116);
    localparam logic [DIF_W-1:0] EPS_K    = DIF_W'(720575940);
    localparam logic [Q_W-1:0]   OUT_MAX  = Q_W'(65536);

    typedef logic signed [DIF_W-1:0] dif_t;
    typedef logic [MAG_W-1:0]        mag_t;

endpackage
`default_nettype wire

FILE: rtl/triangle_tangent_unit.sv
// Triangle tangent unit: top level with its sequencer, shared multiplier,
// square-root and divider steps. Depends on tt_pkg.
//
// Corners arrive one beat at a time. The first two corners of a triangle are
// held; the third starts the tangent calculation and the block drops s_ready
// until it is done. In turn it forms the uv determinant, biases it, and forms
// the epsilon term, the raw tangent (taking the last component after it) and
// the sum of squares; all products go through one 33x33 signed multiplier
// with a 68-bit accumulator. A one-bit-per-cycle shifter then brings the
// largest component into [2^30, 2^31) (an all-zero tangent gives a zero
// result), an integer square root loads the radicand and takes 32 steps,
// the divisor is formed, and a restoring divider takes each component in
// turn. The time s_ready stays low is set mainly by the square root, the
// divider and the number of shifts; it is longer only while the previous
// result still waits unaccepted. The result waits in an output register, so
// new corners may be taken while the previous beat is pending.
`default_nettype none
module triangle_tangent_unit (
    input  wire                     aclk,
    input  wire                     aresetn,
    input  wire                     s_valid,
    output logic                    s_ready,
    input  wire signed [31:0]       s_pos_x,
    input  wire signed [31:0]       s_pos_y,
    input  wire signed [31:0]       s_pos_z,
    input  wire signed [31:0]       s_tex_u,
    input  wire signed [31:0]       s_tex_v,
    output logic                    m_valid,
    input  wire                     m_ready,
    output logic signed [17:0]      m_tangent_x,
    output logic signed [17:0]      m_tangent_y,
    output logic signed [17:0]      m_tangent_z
);

    // Sequencer states
    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_DET   = 4'd1;
    localparam logic [3:0] ST_BIAS  = 4'd2;
    localparam logic [3:0] ST_EPS   = 4'd3;
    localparam logic [3:0] ST_TAN   = 4'd4;
    localparam logic [3:0] ST_WLAST = 4'd5;
    localparam logic [3:0] ST_NORM  = 4'd6;
    localparam logic [3:0] ST_SQ    = 4'd7;
    localparam logic [3:0] ST_SQRT  = 4'd8;
    localparam logic [3:0] ST_NSET  = 4'd9;
    localparam logic [3:0] ST_DIVLD = 4'd10;
    localparam logic [3:0] ST_DIV   = 4'd11;
    localparam logic [3:0] ST_OUT   = 4'd12;

    // Accumulator modes
    localparam logic [1:0] ACC_LOAD  = 2'd0;
    localparam logic [1:0] ACC_ADD   = 2'd1;
    localparam logic [1:0] ACC_SUB   = 2'd2;
    localparam logic [1:0] ACC_SHADD = 2'd3;

    localparam int ACC_W = tt_pkg::ACC_W;
    localparam int MAG_W = tt_pkg::MAG_W;

    logic [3:0]  state_reg, state_next;
    logic [5:0]  step_reg, step_next;
    logic [1:0]  corner_reg, corner_next;
    logic [1:0]  idx_reg, idx_next;

    // Held corners
    logic signed [31:0] p0_reg [3];
    logic signed [31:0] p1_reg [3];
    logic signed [31:0] t0u_reg, t0v_reg, t1u_reg, t1v_reg;

    // Edges and deltas of the current triangle
    tt_pkg::dif_t e0_reg [3];
    tt_pkg::dif_t e1_reg [3];
    tt_pkg::dif_t d0u_reg, d0v_reg, d1u_reg, d1v_reg;

    logic signed [ACC_W-1:0]      acc_reg, acc_next;
    logic [tt_pkg::DS_W-1:0]      dabs_reg;
    logic                         dneg_reg;
    logic [tt_pkg::EPS_W-1:0]     eps_reg, eps_next;
    tt_pkg::mag_t                 mag_reg [3];
    tt_pkg::mag_t                 mag_next [3];
    logic [2:0]                   wneg_reg;
    logic [tt_pkg::RAD_W-1:0]     rem_reg, rem_next;
    logic [tt_pkg::RAD_W-1:0]     root_reg, root_next;
    logic [tt_pkg::RAD_W-1:0]     bit_reg, bit_next;
    logic [tt_pkg::RAD_W-1:0]     n_reg;
    logic [tt_pkg::DEN_W-1:0]     den_reg, den_next;
    logic [tt_pkg::Q_W-1:0]       q_reg, q_next;
    logic [tt_pkg::OUT_W-1:0]     res_reg [3];

    logic s_beat, m_beat;
    assign s_ready = (state_reg == ST_IDLE);
    assign s_beat  = s_valid && s_ready;
    assign m_beat  = m_valid && m_ready;

    // Shared multiplier and accumulator
    logic signed [tt_pkg::DIF_W-1:0]  mul_a, mul_b;
    logic signed [tt_pkg::PROD_W-1:0] prod;
    logic signed [ACC_W-1:0]          prod_x;
    logic [1:0]                       acc_mode;
    logic                             acc_en;

    always_comb begin
        mul_a    = '0;
        mul_b    = '0;
        acc_mode = ACC_LOAD;
        acc_en   = 1'b0;
        case (state_reg)
            ST_DET: begin
                acc_en = 1'b1;
                if (step_reg[0] == 1'b0) begin
                    mul_a = d0u_reg;
                    mul_b = d1v_reg;
                end else begin
                    mul_a    = d1u_reg;
                    mul_b    = d0v_reg;
                    acc_mode = ACC_SUB;
                end
            end
            ST_EPS: begin
                acc_en = 1'b1;
                mul_b  = tt_pkg::EPS_K;
                case (step_reg[1:0])
                    2'd0: mul_a = {1'b0, dabs_reg[31:0]};
                    2'd1: begin
                        mul_a    = {1'b0, dabs_reg[63:32]};
                        acc_mode = ACC_SHADD;
                    end
                    default: begin
                        mul_a    = {17'd0, dabs_reg[79:64]};
                        acc_mode = ACC_SHADD;
                    end
                endcase
            end
            ST_TAN: begin
                acc_en = 1'b1;
                if (step_reg[0] == 1'b0) begin
                    mul_a = d1v_reg;
                    mul_b = e0_reg[step_reg[2:1]];
                end else begin
                    mul_a    = d0v_reg;
                    mul_b    = e1_reg[step_reg[2:1]];
                    acc_mode = ACC_SUB;
                end
            end
            ST_SQ: begin
                acc_en   = 1'b1;
                mul_a    = {2'b00, mag_reg[step_reg[1:0]][30:0]};
                mul_b    = mul_a;
                acc_mode = (step_reg[1:0] == 2'd0) ? ACC_LOAD : ACC_ADD;
            end
            default: begin
                acc_en = 1'b0;
            end
        endcase
    end

    assign prod   = mul_a * mul_b;
    assign prod_x = {{(ACC_W - tt_pkg::PROD_W){prod[tt_pkg::PROD_W-1]}}, prod};

    always_comb begin
        case (acc_mode)
            ACC_LOAD:  acc_next = prod_x;
            ACC_ADD:   acc_next = acc_reg + prod_x;
            ACC_SUB:   acc_next = acc_reg - prod_x;
            ACC_SHADD: acc_next = (acc_reg >>> 32) + prod_x;
            default:   acc_next = prod_x;
        endcase
    end

    // Biased determinant and magnitude of the accumulator
    logic signed [tt_pkg::DS_W-1:0] dsum;
    logic [ACC_W-1:0]               acc_abs;
    assign dsum = ({{(tt_pkg::DS_W - ACC_W){acc_reg[ACC_W-1]}}, acc_reg} <<< 8)
                + $signed(tt_pkg::BIAS_Q40);
    assign acc_abs = acc_reg[ACC_W-1] ? ACC_W'(-acc_reg) : ACC_W'(acc_reg);

    // Normalising shifter
    tt_pkg::mag_t mag_or;
    assign mag_or = mag_reg[0] | mag_reg[1] | mag_reg[2];

    // Square-root and divider steps
    logic [tt_pkg::RAD_W-1:0] sq_trial;
    logic                     sq_take, dv_take;
    assign sq_trial = root_reg + bit_reg;
    assign sq_take  = (rem_reg >= sq_trial);
    assign dv_take  = ({{(tt_pkg::DEN_W - tt_pkg::RAD_W){1'b0}}, rem_reg} >= den_reg);

    // Saturate and apply sign to the finished quotient
    logic [tt_pkg::Q_W-1:0]   q_fin, q_sat;
    logic [tt_pkg::OUT_W-1:0] q_out;
    assign q_fin = {q_reg[tt_pkg::Q_W-2:0], dv_take};
    assign q_sat = (q_fin > tt_pkg::OUT_MAX) ? tt_pkg::OUT_MAX : q_fin;
    assign q_out = (wneg_reg[idx_reg] ^ dneg_reg) ? tt_pkg::OUT_W'(-q_sat)
                                                  : tt_pkg::OUT_W'(q_sat);

    always_comb begin
        state_next  = state_reg;
        step_next   = step_reg;
        corner_next = corner_reg;
        idx_next    = idx_reg;
        eps_next    = eps_reg;
        mag_next    = mag_reg;
        rem_next    = rem_reg;
        root_next   = root_reg;
        bit_next    = bit_reg;
        den_next    = den_reg;
        q_next      = q_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_beat) begin
                    if (corner_reg == 2'd2) begin
                        corner_next = 2'd0;
                        state_next  = ST_DET;
                        step_next   = '0;
                    end else begin
                        corner_next = corner_reg + 2'd1;
                    end
                end
            end
            ST_DET: begin
                step_next = step_reg + 6'd1;
                if (step_reg[0]) begin
                    state_next = ST_BIAS;
                end
            end
            ST_BIAS: begin
                state_next = ST_EPS;
                step_next  = '0;
            end
            ST_EPS: begin
                step_next = step_reg + 6'd1;
                if (step_reg[1:0] == 2'd2) begin
                    state_next = ST_TAN;
                    step_next  = '0;
                end
            end
            ST_TAN: begin
                // Take the epsilon term, then each finished component
                if (step_reg[2:0] == 3'd0) begin
                    eps_next = acc_reg[tt_pkg::EPS_W-1:0];
                end else if (step_reg[0] == 1'b0) begin
                    mag_next[step_reg[2:1] - 2'd1] = acc_abs[MAG_W-1:0];
                end
                step_next = step_reg + 6'd1;
                if (step_reg[2:0] == 3'd5) begin
                    state_next = ST_WLAST;
                end
            end
            ST_WLAST: begin
                mag_next[2] = acc_abs[MAG_W-1:0];
                state_next  = ST_NORM;
            end
            ST_NORM: begin
                if (mag_or == '0) begin
                    state_next = ST_OUT;
                end else if (mag_or[MAG_W-1:31] != '0) begin
                    for (int i = 0; i < 3; i++) begin
                        mag_next[i] = mag_reg[i] >> 1;
                    end
                    eps_next = eps_reg >> 1;
                end else if (!mag_or[30]) begin
                    for (int i = 0; i < 3; i++) begin
                        mag_next[i] = mag_reg[i] << 1;
                    end
                    if (eps_reg > (tt_pkg::EPS_W'(1) << 61)) begin
                        eps_next = tt_pkg::EPS_W'(1) << 62;
                    end else begin
                        eps_next = eps_reg << 1;
                    end
                end else begin
                    state_next = ST_SQ;
                    step_next  = '0;
                end
            end
            ST_SQ: begin
                step_next = step_reg + 6'd1;
                if (step_reg[1:0] == 2'd2) begin
                    state_next = ST_SQRT;
                    step_next  = '0;
                end
            end
            ST_SQRT: begin
                if (step_reg == 6'd0) begin
                    // Load the radicand
                    rem_next  = acc_reg[tt_pkg::RAD_W-1:0];
                    root_next = '0;
                    bit_next  = tt_pkg::RAD_W'(1) << 62;
                    step_next = 6'd1;
                end else begin
                    if (sq_take) begin
                        rem_next  = rem_reg - sq_trial;
                        root_next = (root_reg >> 1) + bit_reg;
                    end else begin
                        root_next = root_reg >> 1;
                    end
                    bit_next  = bit_reg >> 2;
                    step_next = step_reg + 6'd1;
                    if (step_reg == 6'd32) begin
                        state_next = ST_NSET;
                    end
                end
            end
            ST_NSET: begin
                idx_next   = 2'd0;
                state_next = ST_DIVLD;
            end
            ST_DIVLD: begin
                rem_next   = (tt_pkg::RAD_W'(mag_reg[idx_reg][30:0]) << 17) + n_reg;
                den_next   = {n_reg, 18'd0};
                q_next     = '0;
                step_next  = '0;
                state_next = ST_DIV;
            end
            ST_DIV: begin
                if (dv_take) begin
                    rem_next = rem_reg - den_reg[tt_pkg::RAD_W-1:0];
                end
                q_next    = q_fin;
                den_next  = den_reg >> 1;
                step_next = step_reg + 6'd1;
                if (step_reg == 6'(tt_pkg::Q_W - 1)) begin
                    if (idx_reg == 2'd2) begin
                        state_next = ST_OUT;
                    end else begin
                        idx_next   = idx_reg + 2'd1;
                        state_next = ST_DIVLD;
                    end
                end
            end
            ST_OUT: begin
                if (!m_valid || m_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            step_reg   <= '0;
            corner_reg <= '0;
            idx_reg    <= '0;
            m_valid    <= 1'b0;
        end else begin
            state_reg  <= state_next;
            step_reg   <= step_next;
            corner_reg <= corner_next;
            idx_reg    <= idx_next;
            if (state_reg == ST_OUT && (!m_valid || m_ready)) begin
                m_valid <= 1'b1;
            end else if (m_beat) begin
                m_valid <= 1'b0;
            end
        end
    end

    // Datapath
    always_ff @(posedge aclk) begin
        if (s_beat) begin
            if (corner_reg == 2'd0) begin
                p0_reg[0] <= s_pos_x;
                p0_reg[1] <= s_pos_y;
                p0_reg[2] <= s_pos_z;
                t0u_reg   <= s_tex_u;
                t0v_reg   <= s_tex_v;
            end else if (corner_reg == 2'd1) begin
                p1_reg[0] <= s_pos_x;
                p1_reg[1] <= s_pos_y;
                p1_reg[2] <= s_pos_z;
                t1u_reg   <= s_tex_u;
                t1v_reg   <= s_tex_v;
            end else begin
                for (int i = 0; i < 3; i++) begin
                    e0_reg[i] <= 33'(p1_reg[i]) - 33'(p0_reg[i]);
                end
                e1_reg[0] <= 33'(s_pos_x) - 33'(p0_reg[0]);
                e1_reg[1] <= 33'(s_pos_y) - 33'(p0_reg[1]);
                e1_reg[2] <= 33'(s_pos_z) - 33'(p0_reg[2]);
                d0u_reg   <= 33'(t1u_reg) - 33'(t0u_reg);
                d0v_reg   <= 33'(t1v_reg) - 33'(t0v_reg);
                d1u_reg   <= 33'(s_tex_u) - 33'(t0u_reg);
                d1v_reg   <= 33'(s_tex_v) - 33'(t0v_reg);
            end
        end
        if (acc_en) begin
            acc_reg <= acc_next;
        end
        if (state_reg == ST_BIAS) begin
            dneg_reg <= dsum[tt_pkg::DS_W-1];
            dabs_reg <= dsum[tt_pkg::DS_W-1] ? tt_pkg::DS_W'(-dsum) : tt_pkg::DS_W'(dsum);
        end
        if (state_reg == ST_TAN && step_reg[0] == 1'b0 && step_reg[2:0] != 3'd0) begin
            wneg_reg[step_reg[2:1] - 2'd1] <= acc_reg[ACC_W-1];
        end
        if (state_reg == ST_WLAST) begin
            wneg_reg[2] <= acc_reg[ACC_W-1];
        end
        if (state_reg == ST_NORM && mag_or == '0) begin
            for (int i = 0; i < 3; i++) begin
                res_reg[i] <= '0;
            end
        end
        if (state_reg == ST_NSET) begin
            n_reg <= root_reg + tt_pkg::RAD_W'(eps_reg);
        end
        if (state_reg == ST_DIV && step_reg == 6'(tt_pkg::Q_W - 1)) begin
            res_reg[idx_reg] <= q_out;
        end
        if (state_reg == ST_OUT && (!m_valid || m_ready)) begin
            m_tangent_x <= res_reg[0];
            m_tangent_y <= res_reg[1];
            m_tangent_z <= res_reg[2];
        end
        eps_reg  <= eps_next;
        mag_reg  <= mag_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
        bit_reg  <= bit_next;
        den_reg  <= den_next;
        q_reg    <= q_next;
    end

endmodule
`default_nettype wire
